@@ sv/assert_macros.svh @@
// Assertion macros used by the allocator back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ sv/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bfa_pkg
// Types and constants for the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;
  localparam int NumFrames  = 4096;
  localparam int MapWords   = NumFrames / 8;
  localparam int WordAw     = $clog2(MapWords);
  localparam int FrameW     = 12;
  localparam int CountW     = 13;
  localparam int QDepth     = 2;
  localparam logic [CountW-1:0] CounterMax = 13'd8191;
  localparam logic [7:0] FullByte = 8'hFF;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_RESERVE = 2'd3
  } mode_t;

  // Classified request passed from front to back
  typedef struct packed {
    mode_t             mode;
    logic [FrameW-1:0] first;   // first frame
    logic [CountW-1:0] stop;    // one past the last frame, clipped
    logic              empty;   // nothing to touch
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_MODIFY,
    ST_DONE
  } state_t;
endpackage

@@ sv/bfa_front.sv @@
// ----------------------------------------------------------------------------
// bfa_front
// Accepts requests, clips them to the frame limit and queues them.
// ----------------------------------------------------------------------------
module bfa_front import bfa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        mode,
  input  logic [FrameW-1:0] frame_index,
  input  logic [CountW-1:0] range_count,
  input  logic [CountW-1:0] limit,
  input  logic              pop,
  output logic              q_valid,
  output req_t              q_head,
  output logic              q_full
);
  req_t        q_mem [QDepth];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  fill;
  req_t        req_in;
  logic [CountW:0] end_raw;
  logic [CountW-1:0] stop_c;
  logic        push;

  // Classification: compute clipped end and emptiness
  always_comb begin
    end_raw = {2'b00, frame_index} + {1'b0, range_count};
    if (end_raw > {1'b0, limit}) stop_c = limit;
    else stop_c = end_raw[CountW-1:0];
    req_in.mode  = mode_t'(mode);
    req_in.first = frame_index;
    case (mode_t'(mode))
      MODE_ALLOC: begin
        req_in.stop  = limit;
        req_in.empty = (limit == '0);
      end
      MODE_FREE: begin
        req_in.stop  = limit;
        req_in.empty = ({1'b0, frame_index} >= limit);
      end
      default: begin
        req_in.stop  = stop_c;
        req_in.empty = ({1'b0, frame_index} >= stop_c);
      end
    endcase
  end

  assign q_full  = (fill == 2'(QDepth));
  assign q_valid = (fill != 2'd0);
  assign q_head  = q_mem[rd_ptr];
  assign push    = start && !q_full;

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= req_in;
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ sv/bfa_back.sv @@
// ----------------------------------------------------------------------------
// bfa_back
// Carries out queued requests on the used bitmap, one byte per step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bfa_back import bfa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  req_t              q_head,
  output logic              pop,
  output logic              ready,
  output logic              done,
  output logic              success,
  output logic [FrameW-1:0] given_frame,
  output logic [CountW-1:0] frames_in_use
);
  logic [7:0]        map_mem [MapWords];
  logic [7:0]        rd_data;
  logic [WordAw-1:0] rd_addr;
  logic              wr_en;
  logic [WordAw-1:0] wr_addr;
  logic [7:0]        wr_data;

  state_t state, state_next;
  req_t   cur;
  logic [CountW-1:0] pos, pos_next;   // first frame of current byte step
  logic [CountW-1:0] count, count_next;
  logic              ok_next, ok;
  logic [FrameW-1:0] given_next, given;
  logic              last_step;

  // Bit mask of the current byte that lies in [pos, stop)
  logic [7:0] mask, lane_free, lowest;
  logic [CountW-1:0] base;
  logic [2:0] low_idx;
  logic       found;

  assign base = {pos[CountW-1:3], 3'b000};
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[i] = ({1'b0, base} + 14'(i) >= {1'b0, pos})
             && ({1'b0, base} + 14'(i) < {1'b0, cur.stop});
    end
    lane_free = ~rd_data & mask;
    found   = 1'b0;
    low_idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (lane_free[i]) begin
        found   = 1'b1;
        low_idx = 3'(i);
      end
    end
    lowest = 8'(1) << low_idx;
  end

  assign last_step = ({1'b0, base} + 14'd8 >= {1'b0, cur.stop});

  // Bitmap memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
    rd_data <= map_mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (pos == CountW'(MapWords - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (q_valid) state_next = q_head.empty ? ST_DONE : ST_READ;
      ST_READ:   state_next = ST_WAIT;
      ST_WAIT:   state_next = ST_MODIFY;
      ST_MODIFY: begin
        if (cur.mode == MODE_FREE || last_step) state_next = ST_DONE;
        else if (cur.mode == MODE_ALLOC && found) state_next = ST_DONE;
        else state_next = ST_READ;
      end
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    pop        = (state == ST_IDLE) && q_valid;
    ready      = (state != ST_CLEAR);
    rd_addr    = pos[WordAw+2:3];
    wr_en      = 1'b0;
    wr_addr    = pos[WordAw+2:3];
    wr_data    = rd_data;
    pos_next   = pos;
    count_next = count;
    ok_next    = ok;
    given_next = given;
    case (state)
      ST_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = pos[WordAw-1:0];
        wr_data  = FullByte;
        pos_next = pos + 1'b1;
        if (pos == CountW'(MapWords - 1)) pos_next = '0;
      end
      ST_IDLE: begin
        ok_next    = q_valid && q_head.empty
                     && (q_head.mode == MODE_RELEASE || q_head.mode == MODE_RESERVE);
        given_next = '0;
        pos_next   = (q_head.mode == MODE_ALLOC) ? '0 : {1'b0, q_head.first};
      end
      ST_MODIFY: begin
        case (cur.mode)
          MODE_ALLOC: begin
            if (found) begin
              wr_en      = 1'b1;
              wr_data    = rd_data | lowest;
              ok_next    = 1'b1;
              given_next = FrameW'(base) | FrameW'(low_idx);
              if (count != CounterMax) count_next = count + 1'b1;
            end
          end
          MODE_FREE: begin
            if (rd_data[pos[2:0]]) begin
              wr_en   = 1'b1;
              wr_data = rd_data & ~(8'(1) << pos[2:0]);
              ok_next = 1'b1;
              if (count != '0) count_next = count - 1'b1;
            end
          end
          MODE_RELEASE: begin
            wr_en   = 1'b1;
            wr_data = rd_data & ~mask;
            ok_next = 1'b1;
          end
          default: begin
            wr_en   = 1'b1;
            wr_data = rd_data | mask;
            ok_next = 1'b1;
          end
        endcase
        pos_next = base + CountW'(8);
      end
      default: ;
    endcase
    done          = (state == ST_DONE);
    success       = ok;
    given_frame   = given;
    frames_in_use = count;
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      pos   <= '0;
      count <= '0;
      ok    <= 1'b0;
      given <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      count <= count_next;
      ok    <= ok_next;
      given <= given_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_head;
  end

  `ASSERT_IMPL(a_pop_idle, clk, rst, pop, state == ST_IDLE)
  `ASSERT_NEXT(a_done_once, clk, rst, done, !done)
  `ASSERT_IMPL(a_given_ok, clk, rst, done && !success, given_frame == '0)
endmodule

@@ sv/bitmap_frame_allocator.sv @@
// Empty requests go from idle to done; other requests take each byte they
// visit through read, wait and modify (free touches one byte; alloc and
// ranges walk up to 512 bytes). The bitmap engine takes one request at a
// time; a two-entry queue takes requests while it works. After reset a
// clearing pass sets every frame used, with busy high; results cannot be stalled.
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Top level: front request queue, back bitmap engine, limit register.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator import bfa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode,
  input  logic [FrameW-1:0] frame_index,
  input  logic [CountW-1:0] range_count,
  input  logic              cfg_we,
  input  logic [CountW-1:0] cfg_wdata,
  output logic              done,
  output logic              success,
  output logic [FrameW-1:0] given_frame,
  output logic [CountW-1:0] frames_in_use
);
  logic [CountW-1:0] frames_present, limit;
  logic q_valid, q_full, pop, ready;
  req_t q_head;

  // Frame limit register
  always_ff @(posedge clk) begin
    if (rst) frames_present <= CountW'(4096);
    else if (cfg_we) frames_present <= cfg_wdata;
  end
  assign limit = (frames_present > CountW'(NumFrames)) ? CountW'(NumFrames)
                                                        : frames_present;
  assign busy = q_full || !ready;

  bfa_front u_front (
    .clk, .rst,
    .start(start && !busy),
    .mode, .frame_index, .range_count, .limit,
    .pop, .q_valid, .q_head, .q_full
  );

  bfa_back u_back (
    .clk, .rst, .q_valid, .q_head, .pop, .ready,
    .done, .success, .given_frame, .frames_in_use
  );
endmodule

@@ sim/bitmap_frame_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_tb
// Self-checking bench: a directed opening, then randomised phases of alloc,
// free, release and reserve requests under several frames_present settings.
// Every result is checked against a bit-level model of the frame map.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_tb;
  import bfa_pkg::*;

  typedef struct {
    logic              ok;
    logic [FrameW-1:0] frame;
    logic [CountW-1:0] in_use;
  } alloc_result_t;

  // Scoreboard: frame map model plus the queue of expected results
  class frame_scoreboard;
    bit                used [NumFrames];
    logic [CountW-1:0] in_use_count;
    logic [CountW-1:0] frames_present;
    alloc_result_t     pending [$];
    int                mismatches;
    int                checked;

    function void reset_map();
      foreach (used[f]) used[f] = 1'b1;
      in_use_count   = '0;
      frames_present = 13'd4096;
      mismatches     = 0;
      checked        = 0;
    endfunction

    // Work out the result of one accepted transfer and queue it
    function void note_request(mode_t m, logic [FrameW-1:0] idx, logic [CountW-1:0] cnt);
      int            lim;
      int            stop;
      alloc_result_t r;
      lim = (frames_present > NumFrames) ? NumFrames : frames_present;
      r.ok = 1'b0;
      r.frame = '0;
      case (m)
        MODE_ALLOC: begin
          for (int f = 0; f < lim; f++) begin
            if (!used[f]) begin
              used[f] = 1'b1;
              if (in_use_count != CounterMax) in_use_count++;
              r.ok = 1'b1;
              r.frame = f[FrameW-1:0];
              break;
            end
          end
        end
        MODE_FREE: begin
          if (int'(idx) < lim && used[idx]) begin
            used[idx] = 1'b0;
            if (in_use_count != 0) in_use_count--;
            r.ok = 1'b1;
          end
        end
        default: begin
          stop = int'(idx) + int'(cnt);
          if (stop > lim) stop = lim;
          for (int f = idx; f < stop; f++) used[f] = (m == MODE_RESERVE);
          r.ok = 1'b1;
        end
      endcase
      r.in_use = in_use_count;
      pending.push_back(r);
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(logic ok, logic [FrameW-1:0] frame, logic [CountW-1:0] in_use);
      alloc_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result ok=%0b frame=%0d in_use=%0d", ok, frame, in_use);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (ok !== e.ok || frame !== e.frame || in_use !== e.in_use) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d exp ok=%0b frame=%0d in_use=%0d, got ok=%0b frame=%0d in_use=%0d",
                   checked, e.ok, e.frame, e.in_use, ok, frame, in_use);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        mode = '0;
  logic [FrameW-1:0] frame_index = '0;
  logic [CountW-1:0] range_count = '0;
  logic              cfg_we = 1'b0;
  logic [CountW-1:0] cfg_wdata = '0;
  logic              done;
  logic              success;
  logic [FrameW-1:0] given_frame;
  logic [CountW-1:0] frames_in_use;

  frame_scoreboard sb = new();
  int              mode_seen [4];
  int              limits_used;

  always #6 clk = ~clk;

  bitmap_frame_allocator dut (
    .clk, .rst, .start, .busy, .mode, .frame_index, .range_count,
    .cfg_we, .cfg_wdata, .done, .success, .given_frame, .frames_in_use
  );

  // Result monitor
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(success, given_frame, frames_in_use);
  end

  // One request transfer, with a random gap ahead of it
  task automatic send_request(mode_t m, int idx, int cnt);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    mode        <= m;
    frame_index <= idx[FrameW-1:0];
    range_count <= cnt[CountW-1:0];
    do @(posedge clk); while (busy);
    sb.note_request(m, idx[FrameW-1:0], cnt[CountW-1:0]);
    mode_seen[m]++;
  endtask

  // Let every expected result arrive and the engine settle
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(int value);
    drain();
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[CountW-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.frames_present = value[CountW-1:0];
    limits_used++;
  endtask

  // Random request with content biased towards a busy low window
  task automatic random_request(int window);
    int    pick;
    int    idx;
    int    cnt;
    mode_t m;
    pick = $urandom_range(0, 99);
    m = (pick < 35) ? MODE_ALLOC : (pick < 60) ? MODE_FREE :
        (pick < 80) ? MODE_RELEASE : MODE_RESERVE;
    idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, window);
    case ($urandom_range(0, 19))
      0:       cnt = $urandom_range(0, 4096);
      1:       cnt = 0;
      default: cnt = $urandom_range(1, 48);
    endcase
    send_request(m, idx, cnt);
  endtask

  initial begin
    #100_000_000;
    $display("FAIL bitmap_frame_allocator");
    $finish;
  end

  initial begin
    int limits [6];
    sb.reset_map();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // Directed opening: full map, saturation at zero, extremes and clipping
    send_request(MODE_ALLOC, 0, 0);
    send_request(MODE_FREE, 4095, 0);
    send_request(MODE_RELEASE, 0, 4096);
    send_request(MODE_ALLOC, 4095, 8191 & 4096);
    send_request(MODE_ALLOC, 0, 0);
    send_request(MODE_FREE, 1, 0);
    send_request(MODE_FREE, 1, 0);
    send_request(MODE_RESERVE, 4090, 100);
    send_request(MODE_RELEASE, 4095, 1);
    send_request(MODE_RESERVE, 7, 0);
    send_request(MODE_FREE, 4095, 0);
    write_limit(0);
    send_request(MODE_RELEASE, 0, 16);
    send_request(MODE_ALLOC, 0, 0);
    send_request(MODE_FREE, 0, 0);
    write_limit(8191);
    send_request(MODE_RESERVE, 2730, 1365);
    send_request(MODE_ALLOC, 0, 0);
    write_limit(1);
    send_request(MODE_FREE, 0, 0);
    send_request(MODE_RELEASE, 1, 4096);
    send_request(MODE_ALLOC, 0, 0);
    send_request(MODE_ALLOC, 0, 0);
    write_limit(4096);
    send_request(MODE_RELEASE, 0, 64);

    // Random phases under a spread of limits
    limits = '{4096, 200, 8191, 1, 4096 - 8, 0};
    foreach (limits[p]) begin
      int lim;
      lim = (p == 1) ? $urandom_range(2, 300) : limits[p];
      write_limit(lim);
      repeat (180) random_request((lim > 0 && lim < 300) ? lim + 8 : 300);
    end
    write_limit($urandom_range(1, 4096));
    repeat (40) random_request(300);

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d alloc, %0d free, %0d release, %0d reserve requests",
             mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
    $display("over %0d limit settings; %0d results checked, %0d mismatches",
             limits_used, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("PASS bitmap_frame_allocator");
    else
      $display("FAIL bitmap_frame_allocator");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+sv
sv/bfa_pkg.sv
sv/bfa_front.sv
sv/bfa_back.sv
sv/bitmap_frame_allocator.sv
sim/bitmap_frame_allocator_tb.sv
